>>> src/mapd_pkg.sv
`timescale 1ns / 1ps

package mapd_pkg;

    // Result status codes, first failing check wins
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_PSID_NEG    = 3'd1;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd2;
    localparam logic [2:0] ST_SPAN_WIDE   = 3'd3;
    localparam logic [2:0] ST_SPAN_OVER   = 3'd4;
    localparam logic [2:0] ST_OUTSIDE     = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_V4_PREFIX_LENGTH = 3'd0;
    localparam logic [2:0] REG_RULE_V4_PREFIX   = 3'd1;
    localparam logic [2:0] REG_EA_LENGTH        = 3'd2;
    localparam logic [2:0] REG_V6_PREFIX_LENGTH = 3'd3;
    localparam logic [2:0] REG_RULE_V6_HIGH     = 3'd4;
    localparam logic [2:0] REG_RULE_V6_LOW      = 3'd5;

    localparam int IPV4_BITS = 32;
    // 16 port bits minus the fixed 4-bit port offset
    localparam int M_EXP_TOP = 12;

    typedef struct packed {
        logic [5:0]  v4_prefix_length;
        logic [31:0] rule_v4_prefix;
        logic [7:0]  ea_length;
        logic [7:0]  v6_prefix_length;
        logic [63:0] rule_v6_high;
        logic [63:0] rule_v6_low;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [14:0] ea_bits;
        logic [14:0] psid;
        logic [31:0] ipv4_address;
        logic [15:0] ratio_value;
        logic [12:0] m_value;
    } result_t;

endpackage

>>> src/mapd_eval.sv
`timescale 1ns / 1ps

module mapd_eval #(
    parameter int MAX_EA_SPAN = 16
) (
    input  mapd_pkg::cfg_t    cfg,
    input  logic [63:0]       pd_high,
    input  logic [63:0]       pd_low,
    input  logic [7:0]        pd_length,
    output mapd_pkg::result_t result
);

    localparam int SPAN_W = $clog2(MAX_EA_SPAN + 1);

    logic signed [9:0]       psid_bits_s;
    logic signed [9:0]       span_s;
    logic [127:0]            pd_full;
    logic [127:0]            rule_full;
    logic [127:0]            rule_mask;
    logic [127:0]            pd_aligned;
    logic [MAX_EA_SPAN-1:0]  ea_top;
    logic [MAX_EA_SPAN-1:0]  ea_full;
    logic [MAX_EA_SPAN-1:0]  psid_full;
    logic [MAX_EA_SPAN-1:0]  suffix;
    logic [SPAN_W-1:0]       span_n;
    logic [SPAN_W-1:0]       pb;
    logic [SPAN_W-1:0]       ea_shift;
    logic [2:0]              status;

    assign psid_bits_s = $signed({4'b0, cfg.v4_prefix_length})
                       + $signed({2'b0, cfg.ea_length})
                       - 10'(mapd_pkg::IPV4_BITS);
    assign span_s      = $signed({2'b0, pd_length}) - $signed({2'b0, cfg.v6_prefix_length});

    assign pd_full   = {pd_high, pd_low};
    assign rule_full = {cfg.rule_v6_high, cfg.rule_v6_low};
    // Leading rule-length ones; all ones once the rule covers the whole address
    assign rule_mask = ~({128{1'b1}} >> cfg.v6_prefix_length);

    always_comb
    begin
        priority if (psid_bits_s < 10'sd0)
            status = mapd_pkg::ST_PSID_NEG;
        else if (span_s < psid_bits_s)
            status = mapd_pkg::ST_TOO_SHORT;
        else if (span_s >= $signed(10'(MAX_EA_SPAN)))
            status = mapd_pkg::ST_SPAN_WIDE;
        else if (span_s > $signed({2'b0, cfg.ea_length}))
            status = mapd_pkg::ST_SPAN_OVER;
        else if (((pd_full ^ rule_full) & rule_mask) != '0)
            status = mapd_pkg::ST_OUTSIDE;
        else
            status = mapd_pkg::ST_OK;
    end

    // Align the first EA bit to the top, then drop what lies past the span
    assign pd_aligned = pd_full << cfg.v6_prefix_length;
    assign ea_top     = pd_aligned[127 -: MAX_EA_SPAN];
    assign span_n     = span_s[SPAN_W-1:0];
    assign pb         = psid_bits_s[SPAN_W-1:0];
    assign ea_shift   = SPAN_W'(MAX_EA_SPAN) - span_n;
    assign ea_full    = ea_top >> ea_shift;
    assign psid_full  = ea_full & ~({MAX_EA_SPAN{1'b1}} << pb);
    assign suffix     = ea_full >> pb;

    always_comb
    begin
        result = '0;
        result.status = status;
        if (status == mapd_pkg::ST_OK)
        begin
            result.ea_bits      = 15'(ea_full);
            result.psid         = 15'(psid_full);
            result.ipv4_address = cfg.rule_v4_prefix + 32'(suffix);
            result.ratio_value  = 16'd1 << pb;
            if (psid_bits_s <= 10'(mapd_pkg::M_EXP_TOP))
                result.m_value = 13'd1 << (4'(mapd_pkg::M_EXP_TOP) - pb[3:0]);
        end
    end

endmodule

>>> src/map_ea_bits_psid_derive_core.sv
`timescale 1ns / 1ps

// MAP embedded-address bit extraction and PSID derivation.
//
// Channels:
//   config  - cfg_write/cfg_index/cfg_data; register i of the rule is written
//             at the clock edge where cfg_write is high. Unknown indexes drop.
//             Write only while no transaction is in flight.
//   request - a transaction (pd_high, pd_low, pd_length) is taken at the edge
//             where start is high and busy is low. busy never rises: every
//             cycle can carry a new transaction.
//   result  - done strobes for exactly one cycle with status and the derived
//             ea_bits, psid, ipv4_address, ratio_value and m_value.
// Path: an accepted transaction passes the input register, one pass of
// check/extract logic and the result register.
// Throughput: one transaction per cycle; the 128-bit prefix shifter and
// compare are the longest path.
// Reset: clears the rule registers and all valid flags; nothing in flight
// survives. The receiver cannot stall: results are shown once and dropped.
module map_ea_bits_psid_derive_core #(
    parameter int MAX_EA_SPAN = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] pd_high,
    input  logic [63:0] pd_low,
    input  logic [7:0]  pd_length,
    output logic        done,
    output logic [2:0]  status,
    output logic [14:0] ea_bits,
    output logic [14:0] psid,
    output logic [31:0] ipv4_address,
    output logic [15:0] ratio_value,
    output logic [12:0] m_value
);

    mapd_pkg::cfg_t    cfg_reg;
    logic              in_valid_reg;
    logic [63:0]       pd_high_reg;
    logic [63:0]       pd_low_reg;
    logic [7:0]        pd_length_reg;
    logic              done_reg;
    mapd_pkg::result_t result_reg;
    mapd_pkg::result_t result_next;

    // Rule registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mapd_pkg::REG_V4_PREFIX_LENGTH: cfg_reg.v4_prefix_length <= cfg_data[5:0];
                mapd_pkg::REG_RULE_V4_PREFIX:   cfg_reg.rule_v4_prefix   <= cfg_data[31:0];
                mapd_pkg::REG_EA_LENGTH:        cfg_reg.ea_length        <= cfg_data[7:0];
                mapd_pkg::REG_V6_PREFIX_LENGTH: cfg_reg.v6_prefix_length <= cfg_data[7:0];
                mapd_pkg::REG_RULE_V6_HIGH:     cfg_reg.rule_v6_high     <= cfg_data;
                mapd_pkg::REG_RULE_V6_LOW:      cfg_reg.rule_v6_low      <= cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // The request side never backs off
    assign busy = 1'b0;

    // Input stage: valid flag resets, payload just follows the accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            pd_high_reg   <= pd_high;
            pd_low_reg    <= pd_low;
            pd_length_reg <= pd_length;
        end
    end

    // Checks, extraction and derived values in one combinational pass
    mapd_eval #(
        .MAX_EA_SPAN(MAX_EA_SPAN)
    ) u_eval (
        .cfg       (cfg_reg),
        .pd_high   (pd_high_reg),
        .pd_low    (pd_low_reg),
        .pd_length (pd_length_reg),
        .result    (result_next)
    );

    // Result stage: strobe for one cycle, hold payload until the next one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
            result_reg <= result_next;
    end

    assign done         = done_reg;
    assign status       = result_reg.status;
    assign ea_bits      = result_reg.ea_bits;
    assign psid         = result_reg.psid;
    assign ipv4_address = result_reg.ipv4_address;
    assign ratio_value  = result_reg.ratio_value;
    assign m_value      = result_reg.m_value;

endmodule

>>> src/mapd_checker.sv
`timescale 1ns / 1ps

module mapd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [14:0] ea_bits,
    input logic [14:0] psid,
    input logic [31:0] ipv4_address,
    input logic [15:0] ratio_value,
    input logic [12:0] m_value
);

    // Every accepted transaction yields a result through the input and result registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted transaction produced no result");

    // No result without a transaction behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an accepted transaction");

    // Failed checks carry zeroed values
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != mapd_pkg::ST_OK) |->
            (ea_bits == '0 && psid == '0 && ipv4_address == '0
             && ratio_value == '0 && m_value == '0))
        else $error("error result with nonzero values");

    // Good results: ratio and m are zero or a power of two, psid within the EA bits
    a_ok_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == mapd_pkg::ST_OK) |->
            ($onehot0(ratio_value) && $onehot0(m_value) && psid <= ea_bits
             && (psid & ~ea_bits) == '0))
        else $error("inconsistent good result");

endmodule

bind map_ea_bits_psid_derive_core mapd_checker u_mapd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .ea_bits      (ea_bits),
    .psid         (psid),
    .ipv4_address (ipv4_address),
    .ratio_value  (ratio_value),
    .m_value      (m_value)
);
